@@ rtl/cpualu_pkg.sv @@
package cpualu_pkg;

  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_AND   = 5'd4,
    OP_XOR   = 5'd5,
    OP_OR    = 5'd6,
    OP_CP    = 5'd7,
    OP_INC8  = 5'd8,
    OP_DEC8  = 5'd9,
    OP_RLCA  = 5'd10,
    OP_RRCA  = 5'd11,
    OP_RLA   = 5'd12,
    OP_RRA   = 5'd13,
    OP_DAA   = 5'd14,
    OP_CPL   = 5'd15,
    OP_SCF   = 5'd16,
    OP_CCF   = 5'd17,
    OP_ADD16 = 5'd18,
    OP_ADDSP = 5'd19,
    OP_INC16 = 5'd20,
    OP_DEC16 = 5'd21
  } kind_t;

  localparam logic [7:0] DAA_FIX_LO = 8'h06;
  localparam logic [7:0] DAA_FIX_HI = 8'h60;
  localparam logic [7:0] DAA_BCD_MAX = 8'h99;
  localparam logic [3:0] DAA_DIGIT_MAX = 4'h9;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic        zero_in;
    logic        subtract_in;
    logic        half_carry_in;
    logic        carry_in;
  } op_t;

  typedef struct packed {
    logic [15:0] result;
    logic        zero_out;
    logic        subtract_out;
    logic        half_carry_out;
    logic        carry_out;
  } res_t;

endpackage

@@ rtl/cpualu_core.sv @@
module cpualu_core (
  input  cpualu_pkg::op_t  op,
  output cpualu_pkg::res_t res
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic        ci;
  logic [8:0]  sum9;
  logic [4:0]  hsum5;
  logic [8:0]  diff9;
  logic [4:0]  hdiff5;
  logic [7:0]  fix;
  logic [7:0]  daa_r;
  logic [16:0] sum17;
  logic [12:0] hsum13;
  logic [15:0] sp_sum;
  logic [4:0]  sp_h5;
  logic [8:0]  sp_c9;
  logic [7:0]  r8;

  assign a  = op.operand_a[7:0];
  assign b  = op.operand_b[7:0];
  assign ci = op.carry_in &
              ((op.kind == cpualu_pkg::OP_ADC) || (op.kind == cpualu_pkg::OP_SBC));

  assign sum9   = {1'b0, a} + {1'b0, b} + {8'd0, ci};
  assign hsum5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, ci};
  assign diff9  = {1'b0, a} - {1'b0, b} - {8'd0, ci};
  assign hdiff5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, ci};

  // decimal adjust: correction from incoming flags, plus range checks after an add
  always_comb begin
    fix = 8'h00;
    if (op.half_carry_in) begin
      fix = fix | cpualu_pkg::DAA_FIX_LO;
    end
    if (op.carry_in) begin
      fix = fix | cpualu_pkg::DAA_FIX_HI;
    end
    if (op.subtract_in) begin
      daa_r = a - fix;
    end else begin
      if (a[3:0] > cpualu_pkg::DAA_DIGIT_MAX) begin
        fix = fix | cpualu_pkg::DAA_FIX_LO;
      end
      if (a > cpualu_pkg::DAA_BCD_MAX) begin
        fix = fix | cpualu_pkg::DAA_FIX_HI;
      end
      daa_r = a + fix;
    end
  end

  assign sum17  = {1'b0, op.operand_a} + {1'b0, op.operand_b};
  assign hsum13 = {1'b0, op.operand_a[11:0]} + {1'b0, op.operand_b[11:0]};
  assign sp_sum = op.operand_a + {{8{b[7]}}, b};
  assign sp_h5  = {1'b0, op.operand_a[3:0]} + {1'b0, b[3:0]};
  assign sp_c9  = {1'b0, op.operand_a[7:0]} + {1'b0, b};

  always_comb begin
    r8                 = 8'h00;
    res.result         = 16'h0000;
    res.zero_out       = op.zero_in;
    res.subtract_out   = op.subtract_in;
    res.half_carry_out = op.half_carry_in;
    res.carry_out      = op.carry_in;
    case (op.kind)
      cpualu_pkg::OP_ADD, cpualu_pkg::OP_ADC: begin
        r8                 = sum9[7:0];
        res.result         = {8'h00, r8};
        res.zero_out       = (r8 == 8'h00);
        res.subtract_out   = 1'b0;
        res.half_carry_out = hsum5[4];
        res.carry_out      = sum9[8];
      end
      cpualu_pkg::OP_SUB, cpualu_pkg::OP_SBC, cpualu_pkg::OP_CP: begin
        r8                 = diff9[7:0];
        res.result         = (op.kind == cpualu_pkg::OP_CP) ? {8'h00, a} : {8'h00, r8};
        res.zero_out       = (r8 == 8'h00);
        res.subtract_out   = 1'b1;
        res.half_carry_out = hdiff5[4];
        res.carry_out      = diff9[8];
      end
      cpualu_pkg::OP_AND: begin
        r8                 = a & b;
        res.result         = {8'h00, r8};
        res.zero_out       = (r8 == 8'h00);
        res.subtract_out   = 1'b0;
        res.half_carry_out = 1'b1;
        res.carry_out      = 1'b0;
      end
      cpualu_pkg::OP_XOR: begin
        r8                 = a ^ b;
        res.result         = {8'h00, r8};
        res.zero_out       = (r8 == 8'h00);
        res.subtract_out   = 1'b0;
        res.half_carry_out = 1'b0;
        res.carry_out      = 1'b0;
      end
      cpualu_pkg::OP_OR: begin
        r8                 = a | b;
        res.result         = {8'h00, r8};
        res.zero_out       = (r8 == 8'h00);
        res.subtract_out   = 1'b0;
        res.half_carry_out = 1'b0;
        res.carry_out      = 1'b0;
      end
      cpualu_pkg::OP_INC8: begin
        r8                 = a + 8'd1;
        res.result         = {8'h00, r8};
        res.zero_out       = (r8 == 8'h00);
        res.subtract_out   = 1'b0;
        res.half_carry_out = (a[3:0] == 4'hf);
      end
      cpualu_pkg::OP_DEC8: begin
        r8                 = a - 8'd1;
        res.result         = {8'h00, r8};
        res.zero_out       = (r8 == 8'h00);
        res.subtract_out   = 1'b1;
        res.half_carry_out = (a[3:0] == 4'h0);
      end
      cpualu_pkg::OP_RLCA: begin
        res.result         = {8'h00, a[6:0], a[7]};
        res.zero_out       = 1'b0;
        res.subtract_out   = 1'b0;
        res.half_carry_out = 1'b0;
        res.carry_out      = a[7];
      end
      cpualu_pkg::OP_RRCA: begin
        res.result         = {8'h00, a[0], a[7:1]};
        res.zero_out       = 1'b0;
        res.subtract_out   = 1'b0;
        res.half_carry_out = 1'b0;
        res.carry_out      = a[0];
      end
      cpualu_pkg::OP_RLA: begin
        res.result         = {8'h00, a[6:0], op.carry_in};
        res.zero_out       = 1'b0;
        res.subtract_out   = 1'b0;
        res.half_carry_out = 1'b0;
        res.carry_out      = a[7];
      end
      cpualu_pkg::OP_RRA: begin
        res.result         = {8'h00, op.carry_in, a[7:1]};
        res.zero_out       = 1'b0;
        res.subtract_out   = 1'b0;
        res.half_carry_out = 1'b0;
        res.carry_out      = a[0];
      end
      cpualu_pkg::OP_DAA: begin
        res.result         = {8'h00, daa_r};
        res.zero_out       = (daa_r == 8'h00);
        res.half_carry_out = 1'b0;
        res.carry_out      = fix[6];
      end
      cpualu_pkg::OP_CPL: begin
        res.result         = {8'h00, ~a};
        res.subtract_out   = 1'b1;
        res.half_carry_out = 1'b1;
      end
      cpualu_pkg::OP_SCF: begin
        res.result         = {8'h00, a};
        res.subtract_out   = 1'b0;
        res.half_carry_out = 1'b0;
        res.carry_out      = 1'b1;
      end
      cpualu_pkg::OP_CCF: begin
        res.result         = {8'h00, a};
        res.subtract_out   = 1'b0;
        res.half_carry_out = 1'b0;
        res.carry_out      = ~op.carry_in;
      end
      cpualu_pkg::OP_ADD16: begin
        res.result         = sum17[15:0];
        res.subtract_out   = 1'b0;
        res.half_carry_out = hsum13[12];
        res.carry_out      = sum17[16];
      end
      cpualu_pkg::OP_ADDSP: begin
        // flags come from the unsigned low-byte add, not the signed 16-bit one
        res.result         = sp_sum;
        res.zero_out       = 1'b0;
        res.subtract_out   = 1'b0;
        res.half_carry_out = sp_h5[4];
        res.carry_out      = sp_c9[8];
      end
      cpualu_pkg::OP_INC16: begin
        res.result = op.operand_a + 16'd1;
      end
      cpualu_pkg::OP_DEC16: begin
        res.result = op.operand_a - 16'd1;
      end
      default: begin
        res.result = 16'h0000;
      end
    endcase
  end

endmodule

@@ rtl/cpu_alu_with_flags_unit.sv @@
// Flag-producing ALU of an 8-bit CPU: each beat on the op channel carries an
// operation kind, two 16-bit operands and the incoming Z/N/H/C flags, and yields
// one beat on the res channel with the result and the new flags. The unit takes
// one operation every cycle unless the res channel stalls, and each one passes
// through the input register and then the result register around a single pass
// of adders and selection. Unassigned kinds return zero with the flags passed
// through. No state is kept between operations; reset only clears the two valid bits.
module cpu_alu_with_flags_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             op_valid,
  output logic             op_ready,
  input  cpualu_pkg::op_t  op,
  output logic             res_valid,
  input  logic             res_ready,
  output cpualu_pkg::res_t res
);

  cpualu_pkg::op_t  in_reg;
  logic             s1_valid;
  logic             s1_advance;
  cpualu_pkg::res_t core_res;

  assign s1_advance = s1_valid && (!res_valid || res_ready);
  assign op_ready   = !s1_valid || s1_advance;

  cpualu_core u_core (
    .op  (in_reg),
    .res (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (op_ready) begin
        s1_valid <= op_valid;
      end
      if (s1_advance) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_valid && op_ready) begin
      in_reg <= op;
    end
    if (s1_advance) begin
      res <= core_res;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (op_valid && op_ready) |=> s1_valid)
    else $error("accepted beat did not reach the input register");

  a_result_loads: assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> (res_valid && res == $past(core_res)))
    else $error("result register missed the computed beat");

  a_stalled_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_advance) |=> (s1_valid && $stable(in_reg)))
    else $error("stalled input register lost its beat");

  a_ready_when_empty_out: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> op_ready)
    else $error("op channel stalled with an empty result register");
`endif

endmodule
